/* hw/rtl/lfu_cache_replacement_top_assert.svh */
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_REPLACEMENT_TOP_ASSERT_SVH
`define LFU_CACHE_REPLACEMENT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define LFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu assertion failed");
`define LFU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu assertion failed");
`else
`define LFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LFU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache package
// Operation codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

  localparam int OP_BITS  = 2;
  localparam int CAP_BITS = 5;

  localparam logic [OP_BITS-1:0] OP_GET   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_PUT   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_DEC  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  typedef struct packed {
    logic hit;
    logic evicted;
  } lfu_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/lfu_mem.sv */
// ----------------------------------------------------------------------------
// LFU entry memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 84,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lfu_seq.sv */
// ----------------------------------------------------------------------------
// LFU cache sequencer
// Scans the entry memory for match and victim, then rewrites ranks and counts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lfu_cache_replacement_top_assert.svh"

module lfu_seq #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32,
  parameter int COUNT_BITS  = 16,
  parameter int IDX_W       = 4,
  parameter int ENT_W       = 84
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lfu_pkg::OP_BITS-1:0]   op,
  input  wire logic [KEY_BITS-1:0]           key,
  input  wire logic [VALUE_BITS-1:0]         value,
  input  wire logic [lfu_pkg::CAP_BITS-1:0]  cap,
  output logic                               idle,
  output logic                               done_valid,
  input  wire logic                          done_ready,
  output lfu_pkg::lfu_flags_t                flags,
  output logic      [VALUE_BITS-1:0]         read_value,
  output logic      [KEY_BITS-1:0]           evicted_key,
  output logic                               mem_rd_en,
  output logic      [IDX_W-1:0]              mem_rd_addr,
  input  wire logic [ENT_W-1:0]              mem_rd_data,
  output logic                               mem_wr_en,
  output logic      [IDX_W-1:0]              mem_wr_addr,
  output logic      [ENT_W-1:0]              mem_wr_data
);

  import lfu_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CAP_BITS > CNT_W) ? CAP_BITS : CNT_W;
  localparam int R_LO  = 0;
  localparam int C_LO  = IDX_W;
  localparam int V_LO  = IDX_W + COUNT_BITS;
  localparam int K_LO  = IDX_W + COUNT_BITS + VALUE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

  state_t                  state_r, state_nxt;
  logic [OP_BITS-1:0]      op_r, op_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [VALUE_BITS-1:0]   val_r, val_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    issue_r, issue_nxt;
  logic                    pend_r, pend_nxt;
  logic [IDX_W-1:0]        didx_r, didx_nxt;
  logic [MAX_ENTRIES-1:0]  vld_r, vld_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    hit_r, hit_nxt;
  logic [IDX_W-1:0]        hidx_r, hidx_nxt;
  logic [IDX_W-1:0]        hrank_r, hrank_nxt;
  logic [VALUE_BITS-1:0]   hval_r, hval_nxt;
  logic                    vf_r, vf_nxt;
  logic [IDX_W-1:0]        vidx_r, vidx_nxt;
  logic [COUNT_BITS-1:0]   vcnt_r, vcnt_nxt;
  logic [IDX_W-1:0]        vrank_r, vrank_nxt;
  logic [KEY_BITS-1:0]     vkey_r, vkey_nxt;
  logic                    ff_r, ff_nxt;
  logic [IDX_W-1:0]        fidx_r, fidx_nxt;
  logic                    touch_r, touch_nxt;
  logic                    ins_r, ins_nxt;
  logic                    ev_r, ev_nxt;
  logic                    all_r, all_nxt;
  logic [IDX_W-1:0]        thr_r, thr_nxt;
  logic [IDX_W-1:0]        slot_r, slot_nxt;
  logic                    ohit_r, ohit_nxt;

  logic [KEY_BITS-1:0]     e_key;
  logic [VALUE_BITS-1:0]   e_val;
  logic [COUNT_BITS-1:0]   e_cnt;
  logic [IDX_W-1:0]        e_rank;
  logic                    d_vld;
  logic [CMP_W-1:0]        cap_x, cap_eff, cnt_x;
  logic [IDX_W-1:0]        new_rank;
  logic [COUNT_BITS-1:0]   new_cnt;
  logic [VALUE_BITS-1:0]   new_val;

  assign e_key  = mem_rd_data[K_LO +: KEY_BITS];
  assign e_val  = mem_rd_data[V_LO +: VALUE_BITS];
  assign e_cnt  = mem_rd_data[C_LO +: COUNT_BITS];
  assign e_rank = mem_rd_data[R_LO +: IDX_W];
  assign d_vld  = vld_r[didx_r];

  assign cap_x   = CMP_W'(cap);
  assign cap_eff = (cap_x > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_x;
  assign cnt_x   = CMP_W'(cnt_r);

  assign idle        = (state_r == ST_IDLE);
  assign done_valid  = (state_r == ST_FIN);
  assign flags.hit     = ohit_r;
  assign flags.evicted = ev_r;
  assign read_value  = (ohit_r && op_r == OP_GET) ? hval_r : '0;
  assign evicted_key = ev_r ? vkey_r : '0;

  assign mem_rd_en   = issue_r;
  assign mem_rd_addr = idx_r;
  assign mem_wr_addr = didx_r;

  always_comb begin
    new_rank = (all_r || e_rank < thr_r) ? e_rank + 1'b1 : e_rank;
    new_cnt  = e_cnt;
    new_val  = e_val;
    if (touch_r && didx_r == hidx_r) begin
      new_rank = '0;
      new_cnt  = (e_cnt == '1) ? e_cnt : e_cnt + 1'b1;
      new_val  = (op_r == OP_PUT) ? val_r : e_val;
    end
    mem_wr_en   = 1'b0;
    mem_wr_data = {e_key, new_val, new_cnt, new_rank};
    if (state_r == ST_UPD && pend_r) begin
      if (ins_r && didx_r == slot_r) begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {key_r, val_r, COUNT_BITS'(1), IDX_W'(0)};
      end else if (d_vld) begin
        mem_wr_en = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    issue_nxt = 1'b0;
    pend_nxt  = issue_r;
    didx_nxt  = idx_r;
    vld_nxt   = vld_r;
    cnt_nxt   = cnt_r;
    hit_nxt   = hit_r;
    hidx_nxt  = hidx_r;
    hrank_nxt = hrank_r;
    hval_nxt  = hval_r;
    vf_nxt    = vf_r;
    vidx_nxt  = vidx_r;
    vcnt_nxt  = vcnt_r;
    vrank_nxt = vrank_r;
    vkey_nxt  = vkey_r;
    ff_nxt    = ff_r;
    fidx_nxt  = fidx_r;
    touch_nxt = touch_r;
    ins_nxt   = ins_r;
    ev_nxt    = ev_r;
    all_nxt   = all_r;
    thr_nxt   = thr_r;
    slot_nxt  = slot_r;
    ohit_nxt  = ohit_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = op;
          key_nxt   = key;
          val_nxt   = value;
          hit_nxt   = 1'b0;
          vf_nxt    = 1'b0;
          ff_nxt    = 1'b0;
          touch_nxt = 1'b0;
          ins_nxt   = 1'b0;
          ev_nxt    = 1'b0;
          ohit_nxt  = 1'b0;
          idx_nxt   = '0;
          if (op == OP_GET || op == OP_PUT) begin
            issue_nxt = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            if (op == OP_CLEAR) begin
              vld_nxt = '0;
              cnt_nxt = '0;
            end
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (issue_r) begin
          issue_nxt = (idx_r != LAST_IDX);
          idx_nxt   = idx_r + 1'b1;
        end
        if (pend_r) begin
          if (d_vld && e_key == key_r && !hit_r) begin
            hit_nxt   = 1'b1;
            hidx_nxt  = didx_r;
            hrank_nxt = e_rank;
            hval_nxt  = e_val;
          end
          if (d_vld && (!vf_r || e_cnt < vcnt_r || (e_cnt == vcnt_r && e_rank > vrank_r)))
          begin
            vf_nxt    = 1'b1;
            vidx_nxt  = didx_r;
            vcnt_nxt  = e_cnt;
            vrank_nxt = e_rank;
            vkey_nxt  = e_key;
          end
          if (!d_vld && !ff_r) begin
            ff_nxt   = 1'b1;
            fidx_nxt = didx_r;
          end
          if (didx_r == LAST_IDX) begin
            state_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        ohit_nxt  = hit_r;
        state_nxt = ST_FIN;
        all_nxt   = 1'b0;
        thr_nxt   = hrank_r;
        if (hit_r && (op_r == OP_GET || cap_eff != '0)) begin
          touch_nxt = 1'b1;
          state_nxt = ST_UPD;
        end else if (op_r == OP_PUT && cap_eff != '0) begin
          ins_nxt   = 1'b1;
          state_nxt = ST_UPD;
          if (cnt_x >= cap_eff) begin
            ev_nxt          = 1'b1;
            thr_nxt         = vrank_r;
            vld_nxt[vidx_r] = 1'b0;
            slot_nxt        = (ff_r && fidx_r < vidx_r) ? fidx_r : vidx_r;
          end else begin
            all_nxt  = 1'b1;
            slot_nxt = fidx_r;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        if (state_nxt == ST_UPD) begin
          idx_nxt   = '0;
          issue_nxt = 1'b1;
        end
      end
      ST_UPD: begin
        if (issue_r) begin
          issue_nxt = (idx_r != LAST_IDX);
          idx_nxt   = idx_r + 1'b1;
        end
        if (pend_r && didx_r == LAST_IDX) begin
          if (ins_r) begin
            vld_nxt[slot_r] = 1'b1;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (done_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
      vld_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
      vld_r   <= vld_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    didx_r  <= didx_nxt;
    hit_r   <= hit_nxt;
    hidx_r  <= hidx_nxt;
    hrank_r <= hrank_nxt;
    hval_r  <= hval_nxt;
    vf_r    <= vf_nxt;
    vidx_r  <= vidx_nxt;
    vcnt_r  <= vcnt_nxt;
    vrank_r <= vrank_nxt;
    vkey_r  <= vkey_nxt;
    ff_r    <= ff_nxt;
    fidx_r  <= fidx_nxt;
    touch_r <= touch_nxt;
    ins_r   <= ins_nxt;
    ev_r    <= ev_nxt;
    all_r   <= all_nxt;
    thr_r   <= thr_nxt;
    slot_r  <= slot_nxt;
    ohit_r  <= ohit_nxt;
  end

  `LFU_ASSERT_IMP(a_no_rw_clash, clk, rst_n, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr)
  `LFU_ASSERT_IMP(a_cnt_match, clk, rst_n, state_r == ST_IDLE, $countones(vld_r) == 32'(cnt_r))
  `LFU_ASSERT_IMP(a_evict_put, clk, rst_n, done_valid && flags.evicted, op_r == OP_PUT)

endmodule

`default_nettype wire

/* hw/rtl/lfu_cache_replacement_top.sv */
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break, top level
// Fully associative key/value cache with stream ports and a capacity register.
// ----------------------------------------------------------------------------
// One operation at a time. A get or put reads every entry of the entry memory
// once to find the key and the victim, decides in a separate state, and for a
// hit or insert reads and rewrites every entry once more. No new transaction
// is taken until the last one is through, as the entry memory has a single
// read port. A get miss, or a put while capacity is zero, ends after the
// first pass; clear and the unused code go straight to the result. The
// result sits in an output register, so the next transaction is accepted
// while it waits.
`default_nettype none

module lfu_cache_replacement_top #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // operation, key, value
  input  wire logic [((2+KEY_BITS+VALUE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // hit, read_value, evicted, evicted_key
  output logic      [((2+KEY_BITS+VALUE_BITS+7)/8)*8-1:0] out_tdata,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [lfu_pkg::CAP_BITS-1:0]          cfg_data
);

  import lfu_pkg::*;

  localparam int DATA_W = ((2 + KEY_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int PAD_W  = DATA_W - (2 + KEY_BITS + VALUE_BITS);
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ENT_W  = KEY_BITS + VALUE_BITS + COUNT_BITS + IDX_W;

  logic [CAP_BITS-1:0]   cap_r;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0]     out_tdata_r;
  logic                  seq_idle, done_valid, done_ready, start;
  lfu_flags_t            flags;
  logic [VALUE_BITS-1:0] read_value;
  logic [KEY_BITS-1:0]   evicted_key;
  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  logic [ENT_W-1:0]      rd_data, wr_data;

  assign cfg_ready  = 1'b1;
  assign in_tready  = seq_idle;
  assign start      = in_tvalid && in_tready;
  assign done_ready = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_BITS'(16);
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (done_valid && done_ready) begin
      out_tvalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  generate
    if (PAD_W > 0) begin : g_pad
      always_ff @(posedge clk) begin
        if (done_valid && done_ready) begin
          out_tdata_r <= {PAD_W'(0), evicted_key, flags.evicted, read_value, flags.hit};
        end
      end
    end else begin : g_nopad
      always_ff @(posedge clk) begin
        if (done_valid && done_ready) begin
          out_tdata_r <= {evicted_key, flags.evicted, read_value, flags.hit};
        end
      end
    end
  endgenerate

  lfu_mem #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lfu_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .IDX_W       (IDX_W),
    .ENT_W       (ENT_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .op          (in_tdata[OP_BITS-1:0]),
    .key         (in_tdata[OP_BITS +: KEY_BITS]),
    .value       (in_tdata[OP_BITS+KEY_BITS +: VALUE_BITS]),
    .cap         (cap_r),
    .idle        (seq_idle),
    .done_valid  (done_valid),
    .done_ready  (done_ready),
    .flags       (flags),
    .read_value  (read_value),
    .evicted_key (evicted_key),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data)
  );

endmodule

`default_nettype wire
